>>> design/sldt_pkg.sv
// Shared types, codes and constants of the shadow/live P&L drag tracker.
package sldt_pkg;

    // Widths of the fixed-point fields
    localparam int UNIT_W  = 24;
    localparam int MAXP_W  = 31;
    localparam int THR_W   = 63;
    localparam int POS_W   = 32;
    localparam int PRICE_W = 32;
    localparam int ACC_W   = 64;
    localparam int CNT_W   = 32;
    localparam int CFG_W   = 63;
    localparam int IDX_W   = 2;

    // Shared multiplier operand and product widths
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;

    // Rounding shifts for the two signal kinds
    localparam int SHD_SHIFT = 30;
    localparam int LIV_SHIFT = 15;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_UNIT_SIZE      = 2'd0;
    localparam logic [IDX_W-1:0] REG_MAX_POSITION   = 2'd1;
    localparam logic [IDX_W-1:0] REG_DRAG_THRESHOLD = 2'd2;

    // Register reset values
    localparam logic [UNIT_W-1:0] UNIT_RESET = 24'd256;
    localparam logic [MAXP_W-1:0] MAXP_RESET = 31'd25600;
    localparam logic [THR_W-1:0]  THR_RESET  = 63'd65536000;

    typedef enum logic [1:0] {
        OP_SHADOW = 2'd0,
        OP_LIVE   = 2'd1,
        OP_PRICE  = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        MS_BIAS_CONF,
        MS_PROD_UNIT,
        MS_BIAS_UNIT,
        MS_SPOS_DP,
        MS_LPOS_DP
    } mul_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SHD_MUL1,
        ST_SHD_MUL2,
        ST_LIV_MUL,
        ST_RND,
        ST_CLAMP,
        ST_PX_START,
        ST_PX_MUL_S,
        ST_PX_ACC_S,
        ST_PX_ACC_L,
        ST_PX_DRAG,
        ST_PX_ALERT,
        ST_CLEAR,
        ST_DONE
    } state_t;

    // Datapath controls issued by the sequencer
    typedef struct packed {
        logic     idle;
        mul_sel_t mul_sel;
        logic     rnd;
        logic     clamp;
        logic     px_start;
        logic     acc_s;
        logic     acc_l;
        logic     drag;
        logic     alert_chk;
        logic     clr;
        logic     done;
    } ctrl_t;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [15:0] bias;
        logic [15:0]        confidence;
        logic [31:0]        price;
    } in_t;

    typedef struct packed {
        logic               alert;
        logic signed [63:0] drag;
        logic signed [63:0] shd_profit;
        logic signed [63:0] liv_profit;
        logic signed [31:0] shd_holding;
        logic signed [31:0] liv_holding;
        logic [31:0]        px_seen;
        logic [31:0]        alert_total;
    } out_t;

endpackage

>>> design/sldt_mul.sv
// Shared signed multiplier with a registered product.
module sldt_mul
    import sldt_pkg::*;
(
    input  logic                     clk,
    input  logic signed [MUL_W-1:0]  a,
    input  logic signed [MUL_W-1:0]  b,
    output logic signed [PROD_W-1:0] p
);

    logic signed [PROD_W-1:0] p_reg;
    logic signed [PROD_W-1:0] p_next;

    // Form the full product
    assign p_next = PROD_W'(a) * PROD_W'(b);

    // Hold the product for the next step
    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

>>> design/sldt_ctrl.sv
// Sequencer that steps one transaction through the shared multiplier and accumulators.
module sldt_ctrl
    import sldt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] in_op,
    input  logic       seeded,
    input  logic       out_free,
    output ctrl_t      ctrl
);

    state_t state_reg;
    state_t state_next;

    // Advance the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Pick the next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (op_t'(in_op))
                        OP_SHADOW: state_next = ST_SHD_MUL1;
                        OP_LIVE:   state_next = ST_LIV_MUL;
                        OP_PRICE:  state_next = ST_PX_START;
                        OP_CLEAR:  state_next = ST_CLEAR;
                        default:   state_next = ST_CLEAR;
                    endcase
                end
            end
            ST_SHD_MUL1: state_next = ST_SHD_MUL2;
            ST_SHD_MUL2: state_next = ST_RND;
            ST_LIV_MUL:  state_next = ST_RND;
            ST_RND:      state_next = ST_CLAMP;
            ST_CLAMP:    state_next = ST_DONE;
            ST_PX_START: state_next = seeded ? ST_PX_MUL_S : ST_DONE;
            ST_PX_MUL_S: state_next = ST_PX_ACC_S;
            ST_PX_ACC_S: state_next = ST_PX_ACC_L;
            ST_PX_ACC_L: state_next = ST_PX_DRAG;
            ST_PX_DRAG:  state_next = ST_PX_ALERT;
            ST_PX_ALERT: state_next = ST_DONE;
            ST_CLEAR:    state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Drive the datapath controls
    always_comb
    begin
        ctrl         = '0;
        ctrl.mul_sel = MS_BIAS_CONF;
        case (state_reg)
            ST_IDLE:     ctrl.idle = 1'b1;
            ST_SHD_MUL1: ctrl.mul_sel = MS_BIAS_CONF;
            ST_SHD_MUL2: ctrl.mul_sel = MS_PROD_UNIT;
            ST_LIV_MUL:  ctrl.mul_sel = MS_BIAS_UNIT;
            ST_RND:      ctrl.rnd = 1'b1;
            ST_CLAMP:    ctrl.clamp = 1'b1;
            ST_PX_START: ctrl.px_start = 1'b1;
            ST_PX_MUL_S: ctrl.mul_sel = MS_SPOS_DP;
            ST_PX_ACC_S:
            begin
                ctrl.acc_s   = 1'b1;
                ctrl.mul_sel = MS_LPOS_DP;
            end
            ST_PX_ACC_L: ctrl.acc_l = 1'b1;
            ST_PX_DRAG:  ctrl.drag = 1'b1;
            ST_PX_ALERT: ctrl.alert_chk = 1'b1;
            ST_CLEAR:    ctrl.clr = 1'b1;
            ST_DONE:     ctrl.done = 1'b1;
            default:     ctrl.idle = 1'b0;
        endcase
    end

endmodule

>>> design/shadow_live_pnl_drag_tracker.sv
// Top level of the shadow/live P&L drag tracker: registers, datapath and result register.
//
//  channel | signals                        | transfer
//  --------+--------------------------------+-----------------------------------
//  in      | in_valid, in_ready, in_data    | in_valid & in_ready at clk rise
//  out     | out_valid, out_ready, out_data | out_valid & out_ready at clk rise
//  cfg     | cfg_we, cfg_index, cfg_data    | cfg_we at clk rise, no wait
//
// One transaction at a time through one shared 33x33 multiplier under a sequencer.
// A price update after the seed price forms two products and two saturating adds in
// series; the sequencer returns to idle after each result before the next accept.
// in_ready is high only while the sequencer is idle; a held result does not block
// the next accept, but a new result waits until the held one is taken.
// rst_n clears all tracking state and restores the register defaults at once.
module shadow_live_pnl_drag_tracker
    import sldt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_t              in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output out_t             out_data,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    ctrl_t ctrl;

    // Configuration registers
    logic [UNIT_W-1:0] unit_reg;
    logic [MAXP_W-1:0] maxp_reg;
    logic [THR_W-1:0]  thr_reg;

    // Tracking state
    logic signed [POS_W-1:0]  spos_reg;
    logic signed [POS_W-1:0]  lpos_reg;
    logic [PRICE_W-1:0]       last_reg;
    logic                     seeded_reg;
    logic signed [ACC_W-1:0]  sacc_reg;
    logic signed [ACC_W-1:0]  lacc_reg;
    logic signed [ACC_W-1:0]  drag_reg;
    logic                     armed_reg;
    logic [CNT_W-1:0]         upd_reg;
    logic [CNT_W-1:0]         alc_reg;
    logic                     fired_reg;

    // Working registers of one transaction
    in_t                      item_reg;
    logic signed [MUL_W-1:0]  dp_reg;
    logic [POS_W-1:0]         rnd_reg;
    logic                     neg_reg;

    // Result register
    out_t                     out_reg;
    logic                     out_valid_reg;

    // Multiplier connections
    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] prod;

    // Datapath intermediates
    logic                     accept;
    logic                     out_free;
    logic [PROD_W-1:0]        pmag;
    logic [PROD_W-1:0]        rnd_shd;
    logic [PROD_W-1:0]        rnd_liv;
    logic [POS_W-1:0]         clamped;
    logic signed [ACC_W-1:0]  sacc_sum;
    logic signed [ACC_W-1:0]  lacc_sum;
    logic signed [ACC_W-1:0]  drag_diff;
    logic [ACC_W-1:0]         dmag;
    logic [ACC_W-1:0]         half_thr;
    logic                     over_thr;
    logic                     under_half;

    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] b
    );
        logic signed [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (s[ACC_W] != s[ACC_W-1])
        begin
            return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        return s[ACC_W-1:0];
    endfunction

    function automatic logic signed [ACC_W-1:0] sat_sub(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] b
    );
        logic signed [ACC_W:0] s;
        s = {a[ACC_W-1], a} - {b[ACC_W-1], b};
        if (s[ACC_W] != s[ACC_W-1])
        begin
            return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        return s[ACC_W-1:0];
    endfunction

    assign in_ready = ctrl.idle;
    assign accept   = in_valid && ctrl.idle;
    assign out_free = !out_valid_reg || out_ready;

    sldt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_op    (in_data.operation),
        .seeded   (seeded_reg),
        .out_free (out_free),
        .ctrl     (ctrl)
    );

    // Select multiplier operands
    always_comb
    begin
        case (ctrl.mul_sel)
            MS_BIAS_CONF:
            begin
                mul_a = MUL_W'(item_reg.bias);
                mul_b = $signed(MUL_W'(item_reg.confidence));
            end
            MS_PROD_UNIT:
            begin
                mul_a = prod[MUL_W-1:0];
                mul_b = $signed(MUL_W'(unit_reg));
            end
            MS_BIAS_UNIT:
            begin
                mul_a = MUL_W'(item_reg.bias);
                mul_b = $signed(MUL_W'(unit_reg));
            end
            MS_SPOS_DP:
            begin
                mul_a = MUL_W'(spos_reg);
                mul_b = dp_reg;
            end
            MS_LPOS_DP:
            begin
                mul_a = MUL_W'(lpos_reg);
                mul_b = dp_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    sldt_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    // Round the target magnitude to nearest, ties away from zero
    assign pmag    = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
    assign rnd_shd = (pmag + (PROD_W'(1) << (SHD_SHIFT - 1))) >> SHD_SHIFT;
    assign rnd_liv = (pmag + (PROD_W'(1) << (LIV_SHIFT - 1))) >> LIV_SHIFT;

    // Clamp the rounded magnitude to the position limit
    assign clamped = (rnd_reg > POS_W'(maxp_reg)) ? POS_W'(maxp_reg) : rnd_reg;

    // Accumulate and compare
    assign sacc_sum   = sat_add(sacc_reg, prod[ACC_W-1:0]);
    assign lacc_sum   = sat_add(lacc_reg, prod[ACC_W-1:0]);
    assign drag_diff  = sat_sub(sacc_reg, lacc_reg);
    assign dmag       = drag_reg[ACC_W-1] ? ACC_W'(-drag_reg) : ACC_W'(drag_reg);
    assign half_thr   = (ACC_W'(thr_reg) + ACC_W'(1)) >> 1;
    assign over_thr   = dmag > ACC_W'(thr_reg);
    assign under_half = dmag < half_thr;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_reg <= UNIT_RESET;
            maxp_reg <= MAXP_RESET;
            thr_reg  <= THR_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_UNIT_SIZE:      unit_reg <= cfg_data[UNIT_W-1:0];
                REG_MAX_POSITION:   maxp_reg <= cfg_data[MAXP_W-1:0];
                REG_DRAG_THRESHOLD: thr_reg  <= cfg_data[THR_W-1:0];
                default:            unit_reg <= unit_reg;
            endcase
        end
    end

    // Latch the accepted transaction and per-item working values
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_data;
        end
        if (ctrl.rnd)
        begin
            neg_reg <= prod[PROD_W-1];
            rnd_reg <= (op_t'(item_reg.operation) == OP_SHADOW) ? rnd_shd[POS_W-1:0]
                                                                : rnd_liv[POS_W-1:0];
        end
        if (ctrl.px_start)
        begin
            dp_reg <= $signed(MUL_W'(item_reg.price)) - $signed(MUL_W'(last_reg));
        end
    end

    // Update tracking state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spos_reg   <= '0;
            lpos_reg   <= '0;
            last_reg   <= '0;
            seeded_reg <= 1'b0;
            sacc_reg   <= '0;
            lacc_reg   <= '0;
            drag_reg   <= '0;
            armed_reg  <= 1'b1;
            upd_reg    <= '0;
            alc_reg    <= '0;
            fired_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                fired_reg <= 1'b0;
            end
            if (ctrl.clamp)
            begin
                if (op_t'(item_reg.operation) == OP_SHADOW)
                begin
                    spos_reg <= neg_reg ? -$signed(clamped) : $signed(clamped);
                end
                else
                begin
                    lpos_reg <= neg_reg ? -$signed(clamped) : $signed(clamped);
                end
            end
            if (ctrl.px_start)
            begin
                if (upd_reg != '1)
                begin
                    upd_reg <= upd_reg + CNT_W'(1);
                end
                last_reg   <= item_reg.price;
                seeded_reg <= 1'b1;
            end
            if (ctrl.acc_s)
            begin
                sacc_reg <= sacc_sum;
            end
            if (ctrl.acc_l)
            begin
                lacc_reg <= lacc_sum;
            end
            if (ctrl.drag)
            begin
                drag_reg <= drag_diff;
            end
            if (ctrl.alert_chk)
            begin
                if (armed_reg && over_thr)
                begin
                    armed_reg <= 1'b0;
                    fired_reg <= 1'b1;
                    if (alc_reg != '1)
                    begin
                        alc_reg <= alc_reg + CNT_W'(1);
                    end
                end
                else if (!armed_reg && under_half)
                begin
                    armed_reg <= 1'b1;
                end
            end
            if (ctrl.clr)
            begin
                spos_reg   <= '0;
                lpos_reg   <= '0;
                last_reg   <= '0;
                seeded_reg <= 1'b0;
                sacc_reg   <= '0;
                lacc_reg   <= '0;
                drag_reg   <= '0;
                armed_reg  <= 1'b1;
                upd_reg    <= '0;
                alc_reg    <= '0;
            end
        end
    end

    // Hold the result until the consumer takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.done && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (ctrl.done && out_free)
        begin
            out_reg.alert       <= fired_reg;
            out_reg.drag        <= drag_reg;
            out_reg.shd_profit  <= sacc_reg;
            out_reg.liv_profit  <= lacc_reg;
            out_reg.shd_holding <= spos_reg;
            out_reg.liv_holding <= lpos_reg;
            out_reg.px_seen     <= upd_reg;
            out_reg.alert_total <= alc_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

>>> verif/tb_shadow_live_pnl_drag_tracker.sv
// Testbench of the shadow/live P&L drag tracker, checked against a built-in predictor.
`timescale 1ns / 100ps

module tb_shadow_live_pnl_drag_tracker;
    import sldt_pkg::*;

    // Index with no register behind it; writes to it must be ignored
    localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    in_t              in_data = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    out_t             out_data;
    logic             cfg_we = 1'b0;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    // Stimulus bookkeeping
    in_t  tick_queue[$];
    out_t predicted_reports[$];
    int   ticks_sent = 0;
    int   ticks_accepted = 0;
    int   reports_seen = 0;
    int   mismatch_count = 0;
    int   idle_pct = 8;
    logic in_taken = 1'b0;
    logic [31:0] gen_price = '0;

    // Predictor copy of the registers
    logic [UNIT_W-1:0] unit_cfg = UNIT_RESET;
    logic [MAXP_W-1:0] max_pos_cfg = MAXP_RESET;
    logic [THR_W-1:0]  threshold_cfg = THR_RESET;

    // Predictor copy of the tracking state
    logic signed [31:0] shd_position = '0;
    logic signed [31:0] liv_position = '0;
    logic [31:0]        last_px = '0;
    logic               px_seeded = 1'b0;
    logic signed [63:0] shd_pnl = '0;
    logic signed [63:0] liv_pnl = '0;
    logic               alert_armed = 1'b1;
    logic [31:0]        px_count = '0;
    logic [31:0]        alerts_fired = '0;

    shadow_live_pnl_drag_tracker i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Round a magnitude to nearest, ties away from zero, then restore the sign
    function automatic logic signed [63:0] round_shift(logic signed [63:0] v, int s);
        logic [63:0] mag;
        mag = v[63] ? -v : v;
        mag = (mag + (64'd1 << (s - 1))) >> s;
        return v[63] ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic logic signed [31:0] clamp_position(logic signed [63:0] v);
        logic signed [63:0] lim;
        lim = $signed({33'd0, max_pos_cfg});
        if (v > lim)
            v = lim;
        if (v < -lim)
            v = -lim;
        return v[31:0];
    endfunction

    function automatic logic signed [63:0] add_sat(logic signed [63:0] a, logic signed [63:0] b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] sub_sat(logic signed [63:0] a, logic signed [63:0] b);
        logic [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63])
            return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        return s[63:0];
    endfunction

    // Apply one transaction to the tracking state and return the report it yields
    function automatic out_t advance_tracker(in_t item);
        out_t               res;
        logic signed [63:0] b64;
        logic signed [63:0] c64;
        logic signed [63:0] u64;
        logic signed [63:0] s64;
        logic signed [63:0] l64;
        logic signed [63:0] dp;
        logic signed [63:0] drag_v;
        logic [63:0]        mag;
        logic               fired;
        b64 = item.bias;
        c64 = $signed({48'd0, item.confidence});
        u64 = $signed({40'd0, unit_cfg});
        fired = 1'b0;
        case (item.operation)
            OP_SHADOW:
            begin
                shd_position = clamp_position(round_shift(b64 * c64 * u64, SHD_SHIFT));
            end
            OP_LIVE:
            begin
                liv_position = clamp_position(round_shift(b64 * u64, LIV_SHIFT));
            end
            OP_PRICE:
            begin
                if (px_count != '1)
                    px_count++;
                if (!px_seeded)
                begin
                    last_px = item.price;
                    px_seeded = 1'b1;
                end
                else
                begin
                    dp = $signed({32'd0, item.price}) - $signed({32'd0, last_px});
                    last_px = item.price;
                    s64 = shd_position;
                    l64 = liv_position;
                    shd_pnl = add_sat(shd_pnl, s64 * dp);
                    liv_pnl = add_sat(liv_pnl, l64 * dp);
                    drag_v = sub_sat(shd_pnl, liv_pnl);
                    mag = drag_v[63] ? (~drag_v + 64'd1) : drag_v;
                    // Fire once when armed, re-arm below half the threshold
                    if (alert_armed && mag > {1'b0, threshold_cfg})
                    begin
                        alert_armed = 1'b0;
                        fired = 1'b1;
                        if (alerts_fired != '1)
                            alerts_fired++;
                    end
                    else if (!alert_armed && mag < (({1'b0, threshold_cfg}) + 64'd1) >> 1)
                    begin
                        alert_armed = 1'b1;
                    end
                end
            end
            default:
            begin
                shd_position = '0;
                liv_position = '0;
                last_px = '0;
                px_seeded = 1'b0;
                shd_pnl = '0;
                liv_pnl = '0;
                alert_armed = 1'b1;
                px_count = '0;
                alerts_fired = '0;
            end
        endcase
        res.alert = fired;
        res.drag = sub_sat(shd_pnl, liv_pnl);
        res.shd_profit = shd_pnl;
        res.liv_profit = liv_pnl;
        res.shd_holding = shd_position;
        res.liv_holding = liv_position;
        res.px_seen = px_count;
        res.alert_total = alerts_fired;
        return res;
    endfunction

    task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("report %0d: %s expected %h got %h", reports_seen, field, want, got);
        end
    endtask

    // Drive inputs at the falling edge: hold a transaction until it is taken
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            out_ready <= 1'b0;
        end
        else
        begin
            if (!in_valid || in_taken)
            begin
                if (tick_queue.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    in_data <= tick_queue.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            out_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // Sample at the rising edge: track registers, predict and check reports
    always @(posedge clk)
    begin : monitor
        out_t want;
        in_taken = in_valid && in_ready;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_UNIT_SIZE:      unit_cfg = cfg_data[UNIT_W-1:0];
                    REG_MAX_POSITION:   max_pos_cfg = cfg_data[MAXP_W-1:0];
                    REG_DRAG_THRESHOLD: threshold_cfg = cfg_data[THR_W-1:0];
                    default: ;
                endcase
            end
            if (in_taken)
            begin
                predicted_reports.push_back(advance_tracker(in_data));
                ticks_accepted++;
            end
            if (out_valid && out_ready)
            begin
                reports_seen++;
                if (predicted_reports.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("report %0d: no transaction pending, got %h", reports_seen,
                                 out_data);
                end
                else
                begin
                    want = predicted_reports.pop_front();
                    check_field("alert", want.alert, out_data.alert);
                    check_field("drag", want.drag, out_data.drag);
                    check_field("shd_profit", want.shd_profit, out_data.shd_profit);
                    check_field("liv_profit", want.liv_profit, out_data.liv_profit);
                    check_field("shd_holding", want.shd_holding, out_data.shd_holding);
                    check_field("liv_holding", want.liv_holding, out_data.liv_holding);
                    check_field("px_seen", want.px_seen, out_data.px_seen);
                    check_field("alert_total", want.alert_total, out_data.alert_total);
                end
            end
        end
    end

    function automatic logic [CFG_W-1:0] random_word();
        return CFG_W'({$urandom, $urandom});
    endfunction

    task automatic queue_tick(op_t op, logic [15:0] bias, logic [15:0] conf, logic [31:0] price);
        in_t t;
        t.operation = op;
        t.bias = bias;
        t.confidence = conf;
        t.price = price;
        tick_queue.push_back(t);
        ticks_sent++;
        if (op == OP_PRICE)
            gen_price = price;
    endtask

    // Mostly small price moves around the last price, with jumps and extremes
    task automatic queue_random_ticks(int count, int step_bits);
        int          pick;
        int unsigned span;
        longint      nxt;
        logic [15:0] bias_v;
        logic [15:0] conf_v;
        logic [31:0] px_v;
        op_t         op_v;
        span = 1 << step_bits;
        repeat (count)
        begin
            pick = $urandom_range(99);
            if (pick < 22)
                op_v = OP_SHADOW;
            else if (pick < 44)
                op_v = OP_LIVE;
            else if (pick < 97)
                op_v = OP_PRICE;
            else
                op_v = OP_CLEAR;
            case ($urandom_range(9))
                0:       bias_v = 16'h8000;
                1:       bias_v = 16'h7FFF;
                2:       bias_v = 16'h0000;
                default: bias_v = 16'($urandom);
            endcase
            if ($urandom_range(3) == 0)
                conf_v = 16'($urandom);
            else
                conf_v = 16'($urandom_range(32768));
            pick = $urandom_range(19);
            if (pick == 0)
                px_v = 32'h0;
            else if (pick == 1)
                px_v = 32'hFFFF_FFFF;
            else if (pick < 5)
                px_v = $urandom;
            else
            begin
                nxt = longint'(gen_price) + longint'($urandom_range(0, 2 * span)) - span;
                if (nxt < 0)
                    nxt = 0;
                if (nxt > 64'hFFFF_FFFF)
                    nxt = 64'hFFFF_FFFF;
                px_v = nxt[31:0];
            end
            queue_tick(op_v, bias_v, conf_v, px_v);
        end
    endtask

    task automatic write_register(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Hold the sender until every transaction has reported back
    task automatic wait_drained();
        while (ticks_sent != ticks_accepted || predicted_reports.size() != 0)
            @(negedge clk);
    endtask

    // Drain, reprogram all registers, then queue the phase's transactions
    task automatic run_phase(logic [CFG_W-1:0] unit_v, logic [CFG_W-1:0] maxp_v,
                             logic [CFG_W-1:0] thr_v, int pump_reps, int count,
                             int step_bits, int idle_v);
        wait_drained();
        write_register(REG_UNIT_SIZE, unit_v);
        write_register(REG_MAX_POSITION, maxp_v);
        write_register(REG_DRAG_THRESHOLD, thr_v);
        write_register(REG_UNUSED, random_word());
        idle_pct = idle_v;
        @(posedge clk);
        // Swing positions with the price so both accumulators run to saturation
        repeat (pump_reps)
        begin
            queue_tick(OP_SHADOW, 16'h7FFF, 16'hFFFF, $urandom);
            queue_tick(OP_LIVE, 16'h8000, 16'($urandom), $urandom);
            queue_tick(OP_PRICE, 16'($urandom), 16'($urandom), 32'hFFFF_FFFF);
            queue_tick(OP_SHADOW, 16'h8000, 16'hFFFF, $urandom);
            queue_tick(OP_LIVE, 16'h7FFF, 16'($urandom), $urandom);
            queue_tick(OP_PRICE, 16'($urandom), 16'($urandom), 32'h0);
        end
        queue_random_ticks(count, step_bits);
    endtask

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed transactions at the reset register values
        queue_tick(OP_SHADOW, 16'h7FFF, 16'hFFFF, $urandom);   // confidence above 1.0
        queue_tick(OP_LIVE, 16'h8000, 16'($urandom), $urandom);
        queue_tick(OP_PRICE, 16'($urandom), 16'($urandom), 32'h0);       // seed
        queue_tick(OP_PRICE, 16'($urandom), 16'($urandom), 32'hFFFF_FFFF);
        queue_tick(OP_PRICE, 16'($urandom), 16'($urandom), 32'hFFFF_FFFF);
        queue_tick(OP_PRICE, 16'($urandom), 16'($urandom), 32'h0);
        queue_tick(OP_PRICE, 16'($urandom), 16'($urandom), 32'h0000_0100);
        queue_tick(OP_SHADOW, 16'd64, 16'h8000, $urandom);      // rounding tie, positive
        queue_tick(OP_SHADOW, -16'sd64, 16'h8000, $urandom);    // rounding tie, negative
        queue_tick(OP_LIVE, 16'd64, 16'($urandom), $urandom);
        queue_tick(OP_LIVE, -16'sd64, 16'($urandom), $urandom);
        queue_tick(OP_SHADOW, 16'h0000, 16'h0000, $urandom);
        queue_tick(OP_SHADOW, 16'h7FFF, 16'h0000, $urandom);
        queue_tick(OP_PRICE, 16'($urandom), 16'($urandom), 32'h1234_5678);
        queue_tick(OP_CLEAR, 16'($urandom), 16'($urandom), $urandom);
        queue_tick(OP_PRICE, 16'($urandom), 16'($urandom), 32'hFFFF_FFFF);  // seed after clear
        queue_tick(OP_PRICE, 16'($urandom), 16'($urandom), 32'h0);
        queue_tick(OP_SHADOW, 16'h8000, 16'h8000, $urandom);
        queue_tick(OP_LIVE, 16'h7FFF, 16'($urandom), $urandom);
        queue_tick(OP_PRICE, 16'($urandom), 16'($urandom), 32'h0000_0001);
        queue_tick(OP_PRICE, 16'($urandom), 16'($urandom), 32'h8000_0000);
        queue_tick(OP_CLEAR, 16'($urandom), 16'($urandom), $urandom);
        queue_tick(OP_CLEAR, 16'($urandom), 16'($urandom), $urandom);

        // Random register contents, upper bits masked off by the block
        run_phase(random_word(), random_word(), CFG_W'($urandom_range(1 << 20, 1 << 30)),
                  0, 300, 14, 8);
        // Reset-like sizes with a low threshold: alerts and re-arms
        run_phase(CFG_W'(UNIT_RESET), CFG_W'(MAXP_RESET), CFG_W'(32'h0100_0000),
                  0, 350, 14, 8);
        // Largest sizes, zero threshold, no idling on either side
        run_phase(CFG_W'(24'hFF_FFFF), CFG_W'(31'h7FFF_FFFF), '0, 36, 120, 20, 0);
        // Zero sizes and the largest threshold
        run_phase('0, '0, {CFG_W{1'b1}}, 0, 130, 10, 8);
        // Small clamp limit, random threshold
        run_phase(CFG_W'($urandom_range(4096)), CFG_W'($urandom_range(1000)), random_word(),
                  0, 250, 12, 8);
        run_phase(CFG_W'($urandom_range(1 << 16)), random_word(), CFG_W'($urandom) << 8,
                  0, 260, 16, 8);

        wait_drained();
        repeat (20) @(negedge clk);
        if (mismatch_count == 0 && predicted_reports.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
